### design/timing_event_log_decoder_macros.svh
// Assertion macros shared by the timing event log decoder.
`ifndef TIMING_EVENT_LOG_DECODER_MACROS_SVH
`define TIMING_EVENT_LOG_DECODER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TELD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("timing event log decoder: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TELD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("timing event log decoder: next-cycle check failed");

`endif

### design/teld_pkg.sv
// Types and constants of the timing event log decoder.
`timescale 1ns / 1ps

package teld_pkg;

    localparam int CODE_W  = 8;
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [COUNT_W-1:0] TOD_BITS  = 6'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd33;

    localparam logic [CODE_W-1:0] ZERO_BIT_CODE_RST  = 8'd112;
    localparam logic [CODE_W-1:0] ONE_BIT_CODE_RST   = 8'd113;
    localparam logic [CODE_W-1:0] HEARTBEAT_CODE_RST = 8'd122;
    localparam logic [CODE_W-1:0] PPS_CODE_RST       = 8'd125;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ZERO_BIT_CODE  = 2'd0,
        CFG_ONE_BIT_CODE   = 2'd1,
        CFG_HEARTBEAT_CODE = 2'd2,
        CFG_PPS_CODE       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_FIRST_HEARTBEAT = 3'd0,
        KIND_HEARTBEAT_IVL   = 3'd1,
        KIND_PPS_SECONDS     = 3'd2,
        KIND_PPS_BARE        = 3'd3,
        KIND_OTHER_EVENT     = 3'd4
    } report_kind_t;

    typedef struct packed {
        report_kind_t      kind;
        logic [CODE_W-1:0] code;
        logic [TICK_W-1:0] value;
    } report_t;

endpackage

### design/timing_event_log_decoder.sv
// Timing event log decoder: time-of-day assembly, heartbeat and event interval reports.
`timescale 1ns / 1ps

// Takes one timing event or restart request per clock while s_tready is high and
// delivers at most one report per item. Every item is decoded against the code registers
// and the held state, and its report is registered, so the block sustains one item per
// clock while m_tready stays high. A one-entry skid stage keeps s_tready high for one
// more report while a report waits on m_tready. Zero-bit, one-bit and restart items give
// no report. Code registers are written on the cfg channel, which is always ready; write
// them only while the block is idle.
module timing_event_log_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // event_code [7:0], tick_stamp [39:8]
    input  logic        s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // report_code [7:0], report_value [39:8]
    output logic [2:0]  m_tuser,    // report_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [teld_pkg::CODE_W-1:0]  zero_bit_code_reg;
    logic [teld_pkg::CODE_W-1:0]  one_bit_code_reg;
    logic [teld_pkg::CODE_W-1:0]  heartbeat_code_reg;
    logic [teld_pkg::CODE_W-1:0]  pps_code_reg;

    logic [teld_pkg::TICK_W-1:0]  tod_shift_reg;
    logic [teld_pkg::COUNT_W-1:0] tod_bit_count_reg;
    logic                         first_heartbeat_reg;
    logic [teld_pkg::TICK_W-1:0]  last_heartbeat_ticks_reg;
    logic [teld_pkg::TICK_W-1:0]  last_event_ticks_reg;

    logic                         out_valid_reg;
    teld_pkg::report_t            out_reg;
    logic                         skid_valid_reg;
    teld_pkg::report_t            skid_reg;

    logic                         req_type;
    logic [teld_pkg::CODE_W-1:0]  event_code;
    logic [teld_pkg::TICK_W-1:0]  tick_stamp;
    logic                         is_zero_bit;
    logic                         is_one_bit;
    logic                         is_heartbeat;
    logic                         is_pps;
    logic                         in_accept;
    logic                         has_report;
    logic                         produce;
    logic                         out_free;
    teld_pkg::report_t            report_next;
    logic [teld_pkg::COUNT_W-1:0] count_inc;

    assign req_type   = s_tuser;
    assign event_code = s_tdata[7:0];
    assign tick_stamp = s_tdata[39:8];

    // Overlapping codes resolve in the order zero bit, one bit, heartbeat, PPS.
    assign is_zero_bit  = (event_code == zero_bit_code_reg);
    assign is_one_bit   = !is_zero_bit && (event_code == one_bit_code_reg);
    assign is_heartbeat = !is_zero_bit && !is_one_bit && (event_code == heartbeat_code_reg);
    assign is_pps       = !is_zero_bit && !is_one_bit && !is_heartbeat &&
                          (event_code == pps_code_reg);

    assign s_tready   = !skid_valid_reg;
    assign in_accept  = s_tvalid && s_tready;
    assign has_report = !req_type && !is_zero_bit && !is_one_bit;
    assign produce    = in_accept && has_report;
    assign out_free   = !out_valid_reg || m_tready;
    assign cfg_ready  = 1'b1;

    assign count_inc = (tod_bit_count_reg < teld_pkg::COUNT_MAX) ?
                       tod_bit_count_reg + 6'd1 : tod_bit_count_reg;

    always_comb begin
        report_next.code = event_code;
        if (is_heartbeat) begin
            if (first_heartbeat_reg) begin
                report_next.kind  = teld_pkg::KIND_FIRST_HEARTBEAT;
                report_next.value = '0;
            end else begin
                report_next.kind  = teld_pkg::KIND_HEARTBEAT_IVL;
                report_next.value = tick_stamp - last_heartbeat_ticks_reg;
            end
        end else if (is_pps) begin
            if (tod_bit_count_reg == teld_pkg::TOD_BITS) begin
                report_next.kind  = teld_pkg::KIND_PPS_SECONDS;
                report_next.value = tod_shift_reg;
            end else begin
                report_next.kind  = teld_pkg::KIND_PPS_BARE;
                report_next.value = '0;
            end
        end else begin
            report_next.kind  = teld_pkg::KIND_OTHER_EVENT;
            report_next.value = tick_stamp - last_event_ticks_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_bit_code_reg  <= teld_pkg::ZERO_BIT_CODE_RST;
            one_bit_code_reg   <= teld_pkg::ONE_BIT_CODE_RST;
            heartbeat_code_reg <= teld_pkg::HEARTBEAT_CODE_RST;
            pps_code_reg       <= teld_pkg::PPS_CODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (teld_pkg::cfg_index_t'(cfg_index))
                teld_pkg::CFG_ZERO_BIT_CODE:  zero_bit_code_reg  <= cfg_data;
                teld_pkg::CFG_ONE_BIT_CODE:   one_bit_code_reg   <= cfg_data;
                teld_pkg::CFG_HEARTBEAT_CODE: heartbeat_code_reg <= cfg_data;
                teld_pkg::CFG_PPS_CODE:       pps_code_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tod_shift_reg            <= '0;
            tod_bit_count_reg        <= '0;
            first_heartbeat_reg      <= 1'b1;
            last_heartbeat_ticks_reg <= '0;
            last_event_ticks_reg     <= '0;
        end else if (in_accept) begin
            if (req_type) begin
                first_heartbeat_reg <= 1'b1;
                tod_bit_count_reg   <= '0;
            end else if (is_zero_bit || is_one_bit) begin
                tod_shift_reg     <= {tod_shift_reg[teld_pkg::TICK_W-2:0], is_one_bit};
                tod_bit_count_reg <= count_inc;
            end else if (is_heartbeat) begin
                first_heartbeat_reg      <= 1'b0;
                last_heartbeat_ticks_reg <= tick_stamp;
            end else if (is_pps) begin
                tod_bit_count_reg <= '0;
            end else begin
                last_event_ticks_reg <= tick_stamp;
            end
        end
    end

    // The skid entry is older than any new report, so it drains into the output first;
    // while it is full s_tready is low and nothing new arrives.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= produce;
            end
        end else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (produce) begin
                out_reg <= report_next;
            end
        end else if (produce) begin
            skid_reg <= report_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.value, out_reg.code};
    assign m_tuser  = out_reg.kind;

`include "timing_event_log_decoder_macros.svh"

    `TELD_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `TELD_ASSERT_IMP(a_count_saturates, aclk, aresetn, 1'b1, tod_bit_count_reg <= teld_pkg::COUNT_MAX)
    `TELD_ASSERT_NXT(a_restart_clears, aclk, aresetn, in_accept && req_type, tod_bit_count_reg == '0 && first_heartbeat_reg)
    `TELD_ASSERT_NXT(a_stall_to_skid, aclk, aresetn, produce && !out_free, skid_valid_reg)

endmodule
